// ----- hdl/svpwm_pkg.sv -----
// ============================================================================
// svpwm_pkg
// Shared types and constants for the servo PWM slew generator.
// ============================================================================
package svpwm_pkg;

    localparam int FIELD_W    = 16;
    localparam int TRIM_W     = 8;
    localparam int RAMP_W     = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WIDTH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIM_OFFSET  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_STEP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_FRAMES  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH = 3'd5;

    localparam logic [FIELD_W-1:0] RST_MIN_WIDTH    = 16'd500;
    localparam logic [FIELD_W-1:0] RST_MAX_WIDTH    = 16'd1700;
    localparam logic [TRIM_W-1:0]  RST_TRIM_OFFSET  = 8'd0;
    localparam logic [FIELD_W-1:0] RST_MIN_STEP     = 16'd20;
    localparam logic [RAMP_W-1:0]  RST_RAMP_FRAMES  = 10'd0;
    localparam logic [FIELD_W-1:0] RST_FRAME_LENGTH = 16'd20000;
    localparam int                 RST_WIDTH        = 1500;

    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_SET  = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [FIELD_W-1:0] requested_width;
    } in_item_t;

    typedef struct packed {
        logic               pwm_level;
        logic               frame_start;
        logic [FIELD_W-1:0] present_width_out;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_UPD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic div_start;
        logic update;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
    } status_t;

endpackage

// ----- hdl/svpwm_div.sv -----
// ============================================================================
// svpwm_div
// Restoring divider, one quotient bit per cycle.
// ============================================================================
module svpwm_div #(
    parameter int DW = 16,
    parameter int VW = 10
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic [DW-1:0] quotient,
    output logic          done
);

    localparam int CW = $clog2(DW + 1);

    logic          busy_reg, busy_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [VW-1:0] dvs_reg, dvs_next;
    logic [VW:0]   trial;
    logic [VW:0]   diff;

    assign trial = {rem_reg, quo_reg[DW-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(DW);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = diff[VW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end else begin
                rem_next = trial[VW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = quo_reg;
    assign done     = !busy_reg;

endmodule

// ----- hdl/svpwm_ctrl.sv -----
// ============================================================================
// svpwm_ctrl
// Sequencer: accepts an item, runs the divider when needed, updates state
// and hands the result to the output register.
// ============================================================================
module svpwm_ctrl
    import svpwm_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (status.need_div) begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIV;
                    end else begin
                        state_next = ST_UPD;
                    end
                end
            end
            ST_DIV: begin
                if (status.div_done) begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                cmd.update = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ----- hdl/svpwm_dpath.sv -----
// ============================================================================
// svpwm_dpath
// Configuration registers, width and frame state, step arithmetic and the
// output register.
// ============================================================================
module svpwm_dpath
    import svpwm_pkg::*;
#(
    parameter int TRIM_LIMIT = 100,
    parameter int WIDTH_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  in_item_t              s_item,
    output out_item_t             m_item,
    input  cmd_t                  cmd,
    output status_t               status
);

    localparam int                     SW     = FIELD_W + 2;
    localparam logic signed [SW-1:0]   TL_POS = SW'(TRIM_LIMIT);
    localparam logic signed [SW-1:0]   TL_NEG = -SW'(TRIM_LIMIT);
    localparam logic [FIELD_W-1:0]     WMAX   = FIELD_W'((2 ** WIDTH_BITS) - 1);

    logic [FIELD_W-1:0]    min_width_reg, max_width_reg, min_step_reg, frame_len_reg;
    logic [TRIM_W-1:0]     trim_reg;
    logic [RAMP_W-1:0]     ramp_reg;

    logic [WIDTH_BITS-1:0] present_reg, present_next;
    logic [WIDTH_BITS-1:0] goal_reg, goal_next;
    logic [FIELD_W-1:0]    pos_reg, pos_next;
    in_item_t              item_reg;
    out_item_t             res_reg, res_next;
    out_item_t             m_item_reg;

    logic                  frame_zero;
    logic                  ramp_nz;
    logic [WIDTH_BITS-1:0] diff;
    logic [WIDTH_BITS-1:0] quo;
    logic [FIELD_W-1:0]    step;
    logic [WIDTH_BITS-1:0] new_present;
    logic signed [SW-1:0]  trim_ext, trim_sat, w_sum;
    logic [FIELD_W-1:0]    clamp_w, sat_w;
    logic [FIELD_W:0]      pos_inc;
    logic                  div_done;

    assign frame_zero = (pos_reg == '0);
    assign ramp_nz    = (ramp_reg != '0);
    assign diff       = (present_reg > goal_reg) ? (present_reg - goal_reg)
                                                 : (goal_reg - present_reg);

    assign status.need_div = (s_item.req_type == REQ_TICK) && frame_zero && ramp_nz;
    assign status.div_done = div_done;

    svpwm_div #(
        .DW(WIDTH_BITS),
        .VW(RAMP_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (diff),
        .divisor  (ramp_reg),
        .quotient (quo),
        .done     (div_done)
    );

    always_comb begin
        step = min_step_reg;
        if (ramp_nz && (FIELD_W'(quo) > min_step_reg)) begin
            step = FIELD_W'(quo);
        end
        if (FIELD_W'(diff) <= step) begin
            new_present = goal_reg;
        end else if (present_reg < goal_reg) begin
            new_present = present_reg + step[WIDTH_BITS-1:0];
        end else begin
            new_present = present_reg - step[WIDTH_BITS-1:0];
        end
    end

    always_comb begin
        trim_ext = SW'(signed'(trim_reg));
        if (trim_ext > TL_POS) begin
            trim_sat = TL_POS;
        end else if (trim_ext < TL_NEG) begin
            trim_sat = TL_NEG;
        end else begin
            trim_sat = trim_ext;
        end
        w_sum = signed'({2'b00, item_reg.requested_width}) + trim_sat;
        if (w_sum < signed'({2'b00, min_width_reg})) begin
            clamp_w = min_width_reg;
        end else if (w_sum > signed'({2'b00, max_width_reg})) begin
            clamp_w = max_width_reg;
        end else begin
            clamp_w = w_sum[FIELD_W-1:0];
        end
        sat_w = (clamp_w > WMAX) ? WMAX : clamp_w;
    end

    always_comb begin
        present_next = present_reg;
        goal_next    = goal_reg;
        pos_next     = pos_reg;
        res_next     = res_reg;
        pos_inc      = {1'b0, pos_reg} + 1'b1;
        if (cmd.update) begin
            if (item_reg.req_type == REQ_SET) begin
                goal_next                  = sat_w[WIDTH_BITS-1:0];
                res_next.pwm_level         = 1'b0;
                res_next.frame_start       = 1'b0;
                res_next.present_width_out = FIELD_W'(present_reg);
            end else begin
                if (frame_zero) begin
                    present_next = new_present;
                end
                res_next.frame_start       = frame_zero;
                res_next.pwm_level         = (pos_reg < FIELD_W'(present_next));
                res_next.present_width_out = FIELD_W'(present_next);
                pos_next = (pos_inc >= {1'b0, frame_len_reg}) ? '0 : pos_inc[FIELD_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_width_reg <= RST_MIN_WIDTH;
            max_width_reg <= RST_MAX_WIDTH;
            trim_reg      <= RST_TRIM_OFFSET;
            min_step_reg  <= RST_MIN_STEP;
            ramp_reg      <= RST_RAMP_FRAMES;
            frame_len_reg <= RST_FRAME_LENGTH;
            present_reg   <= WIDTH_BITS'(RST_WIDTH);
            goal_reg      <= WIDTH_BITS'(RST_WIDTH);
            pos_reg       <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_MIN_WIDTH:    min_width_reg <= cfg_data;
                    CFG_MAX_WIDTH:    max_width_reg <= cfg_data;
                    CFG_TRIM_OFFSET:  trim_reg      <= cfg_data[TRIM_W-1:0];
                    CFG_MIN_STEP:     min_step_reg  <= cfg_data;
                    CFG_RAMP_FRAMES:  ramp_reg      <= cfg_data[RAMP_W-1:0];
                    CFG_FRAME_LENGTH: frame_len_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
            present_reg <= present_next;
            goal_reg    <= goal_next;
            pos_reg     <= pos_next;
        end
        if (cmd.load) begin
            item_reg <= s_item;
        end
        res_reg <= res_next;
        if (cmd.emit) begin
            m_item_reg <= res_reg;
        end
    end

    assign m_item = m_item_reg;

endmodule

// ----- hdl/servo_pwm_slew_generator.sv -----
// ============================================================================
// servo_pwm_slew_generator
// Hobby servo PWM generator with per-frame slew-rate limiting.
// ============================================================================
// Each item is either a one-microsecond tick or a new target width; every
// item returns one result. The first tick of a frame with ramp_frames
// nonzero runs the distance / ramp_frames division through a restoring
// divider at one quotient bit per cycle; other items skip the divider. A
// new item is taken while the previous result waits in the output
// register. Configuration writes are always ready.
module servo_pwm_slew_generator
    import svpwm_pkg::*;
#(
    parameter int TRIM_LIMIT = 100,
    parameter int WIDTH_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_item,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    svpwm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    svpwm_dpath #(
        .TRIM_LIMIT(TRIM_LIMIT),
        .WIDTH_BITS(WIDTH_BITS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_item    (s_item),
        .m_item    (m_item),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ----- test/servo_pwm_slew_generator_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// servo_pwm_slew_generator_tb
// Self-checking bench for the servo PWM slew generator.
// ============================================================================
// Directed rows cover reset behavior, clamping and trim saturation, step
// extremes, ramp division, zero frame length, widths past the frame and
// ignored register writes. Random phases reprogram every register, then stream
// ticks and set-target items. Each result is checked against its row's value
// or a PWM/slew predictor, with bursty input and a patterned output stall.
module servo_pwm_slew_generator_tb;
    import svpwm_pkg::*;

    localparam int TRIM_SAT    = 100;
    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_ITEMS = 600;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    typedef enum logic [1:0] {ROW_TICK, ROW_SET, ROW_CFG} row_kind_t;
    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_pattern_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [15:0]           value;
        logic                  typed;
        out_item_t             want;
    } dir_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_item    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // predictor copy of registers and state
    logic [15:0] cfg_min_w     = RST_MIN_WIDTH;
    logic [15:0] cfg_max_w     = RST_MAX_WIDTH;
    logic [7:0]  cfg_trim      = RST_TRIM_OFFSET;
    logic [15:0] cfg_step      = RST_MIN_STEP;
    logic [9:0]  cfg_ramp      = RST_RAMP_FRAMES;
    logic [15:0] cfg_frame_len = RST_FRAME_LENGTH;
    logic [15:0] cur_w         = 16'(RST_WIDTH);
    logic [15:0] goal_w        = 16'(RST_WIDTH);
    int          frame_pos     = 0;

    out_item_t   pwm_expected_q[$];
    out_item_t   oldest_want;
    dir_row_t    dir_rows[$];

    int          mismatches   = 0;
    int          results_seen = 0;
    int          frames_seen  = 0;
    int          items_sent   = 0;
    int          sets_sent    = 0;
    int          cfg_writes   = 0;
    int          burst_left   = 0;
    int          cycle_count  = 0;

    rx_pattern_t rx_pattern;
    int          rx_pattern_left;
    int          rx_taken;
    int          hold_left;
    int          next_hold_at;

    always #10 aclk = ~aclk;

    servo_pwm_slew_generator #(
        .TRIM_LIMIT(TRIM_SAT),
        .WIDTH_BITS(16)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic out_item_t predict_pwm(in_item_t it);
        int        trim;
        int        req;
        int        span;
        int        step;
        out_item_t r;
        r = '0;
        if (it.req_type == REQ_SET) begin
            trim = int'($signed(cfg_trim));
            if (trim > TRIM_SAT) trim = TRIM_SAT;
            else if (trim < -TRIM_SAT) trim = -TRIM_SAT;
            req = int'(it.requested_width) + trim;
            if (req < int'(cfg_min_w)) goal_w = cfg_min_w;
            else if (req > int'(cfg_max_w)) goal_w = cfg_max_w;
            else goal_w = req[15:0];
        end else begin
            if (frame_pos == 0) begin
                r.frame_start = 1'b1;
                span = (cur_w > goal_w) ? int'(cur_w - goal_w) : int'(goal_w - cur_w);
                step = int'(cfg_step);
                if (cfg_ramp != 0 && span / int'(cfg_ramp) > step) step = span / int'(cfg_ramp);
                if (span <= step) cur_w = goal_w;
                else if (cur_w < goal_w) cur_w = cur_w + 16'(step);
                else cur_w = cur_w - 16'(step);
            end
            r.pwm_level = (frame_pos < int'(cur_w));
            frame_pos++;
            if (frame_pos >= int'(cfg_frame_len)) frame_pos = 0;
        end
        r.present_width_out = cur_w;
        return r;
    endfunction

    function automatic dir_row_t tick_row(logic typed, logic lvl, logic start,
                                          logic [15:0] pw);
        dir_row_t r;
        r.kind    = ROW_TICK;
        r.reg_idx = '0;
        r.value   = 16'($urandom);
        r.typed   = typed;
        r.want    = '{lvl, start, pw};
        return r;
    endfunction

    function automatic dir_row_t set_row(logic [15:0] w, logic typed, logic [15:0] pw);
        dir_row_t r;
        r.kind    = ROW_SET;
        r.reg_idx = '0;
        r.value   = w;
        r.typed   = typed;
        r.want    = '{1'b0, 1'b0, pw};
        return r;
    endfunction

    function automatic dir_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
        dir_row_t r;
        r.kind    = ROW_CFG;
        r.reg_idx = idx;
        r.value   = data;
        r.typed   = 1'b0;
        r.want    = '0;
        return r;
    endfunction

    task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    endtask

    task automatic send_item(in_item_t it, logic typed, out_item_t want);
        out_item_t predicted;
        s_item  <= it;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = predict_pwm(it);
        pwm_expected_q.push_back(typed ? want : predicted);
        items_sent++;
        if (it.req_type == REQ_SET) sets_sent++;
    endtask

    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
    endtask

    task automatic wait_drain();
        s_valid <= 1'b0;
        while (pwm_expected_q.size() != 0) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_MIN_WIDTH:    cfg_min_w     = data;
            CFG_MAX_WIDTH:    cfg_max_w     = data;
            CFG_TRIM_OFFSET:  cfg_trim      = data[7:0];
            CFG_MIN_STEP:     cfg_step      = data;
            CFG_RAMP_FRAMES:  cfg_ramp      = data[9:0];
            CFG_FRAME_LENGTH: cfg_frame_len = data;
            default: ;
        endcase
        cfg_writes++;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pwm_expected_q.size() == 0) begin
                flag_mismatch("unexpected item, width", 32'd0, 32'(m_item.present_width_out));
            end else begin
                oldest_want = pwm_expected_q.pop_front();
                if (m_item.pwm_level !== oldest_want.pwm_level)
                    flag_mismatch("pwm_level", 32'(oldest_want.pwm_level),
                                  32'(m_item.pwm_level));
                if (m_item.frame_start !== oldest_want.frame_start)
                    flag_mismatch("frame_start", 32'(oldest_want.frame_start),
                                  32'(m_item.frame_start));
                if (m_item.present_width_out !== oldest_want.present_width_out)
                    flag_mismatch("present_width_out", 32'(oldest_want.present_width_out),
                                  32'(m_item.present_width_out));
                results_seen++;
                if (m_item.frame_start === 1'b1) frames_seen++;
            end
        end
    end

    // output stall pattern with periodic long hold-offs
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready         <= 1'b0;
            rx_pattern      <= RX_OPEN;
            rx_pattern_left <= 0;
            rx_taken        <= 0;
            hold_left       <= 0;
            next_hold_at    <= 150;
        end else begin
            if (m_valid && m_ready) rx_taken <= rx_taken + 1;
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else if (rx_taken >= next_hold_at) begin
                hold_left    <= 300;
                next_hold_at <= next_hold_at + 300;
                m_ready      <= 1'b0;
            end else begin
                if (rx_pattern_left == 0) begin
                    rx_pattern      <= rx_pattern_t'($urandom_range(0, 3));
                    rx_pattern_left <= $urandom_range(16, 96);
                end else begin
                    rx_pattern_left <= rx_pattern_left - 1;
                end
                case (rx_pattern)
                    RX_OPEN:   m_ready <= 1'b1;
                    RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                    default:   m_ready <= ~m_ready;
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d items still expected",
                     cycle_count, pwm_expected_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        in_item_t    it;
        int          n;
        int          set_pct;
        int          ph;
        int          random_sent;
        logic [15:0] wmax;
        logic [15:0] min_v;
        logic [15:0] max_v;
        logic [15:0] step_v;
        logic [15:0] frame_v;
        logic [7:0]  trim_v;
        logic [9:0]  ramp_v;

        // reset defaults, then clamps and trim saturation
        dir_rows.push_back(tick_row(1'b1, 1'b1, 1'b1, 16'd1500));
        dir_rows.push_back(set_row(16'd0, 1'b1, 16'd1500));
        dir_rows.push_back(tick_row(1'b1, 1'b1, 1'b0, 16'd1500));
        dir_rows.push_back(cfg_row(CFG_FRAME_LENGTH, 16'd3));
        dir_rows.push_back(tick_row(1'b1, 1'b1, 1'b0, 16'd1500));
        dir_rows.push_back(tick_row(1'b1, 1'b1, 1'b1, 16'd1480));
        dir_rows.push_back(set_row(16'hFFFF, 1'b1, 16'd1480));
        dir_rows.push_back(cfg_row(CFG_TRIM_OFFSET, 16'h0080));
        dir_rows.push_back(cfg_row(CFG_MIN_WIDTH, 16'd0));
        dir_rows.push_back(cfg_row(CFG_MAX_WIDTH, 16'hFFFF));
        dir_rows.push_back(set_row(16'd0, 1'b1, 16'd1480));
        dir_rows.push_back(cfg_row(CFG_TRIM_OFFSET, 16'h007F));
        dir_rows.push_back(set_row(16'hFFFF, 1'b1, 16'd1480));
        // largest step snaps to goal
        dir_rows.push_back(cfg_row(CFG_MIN_STEP, 16'hFFFF));
        dir_rows.push_back(tick_row(1'b1, 1'b1, 1'b0, 16'd1480));
        dir_rows.push_back(tick_row(1'b1, 1'b1, 1'b0, 16'd1480));
        dir_rows.push_back(tick_row(1'b1, 1'b1, 1'b1, 16'hFFFF));
        // zero frame length acts as one tick per frame
        dir_rows.push_back(cfg_row(CFG_FRAME_LENGTH, 16'd0));
        dir_rows.push_back(tick_row(1'b1, 1'b1, 1'b0, 16'hFFFF));
        dir_rows.push_back(tick_row(1'b1, 1'b1, 1'b1, 16'hFFFF));
        // min above max
        dir_rows.push_back(cfg_row(CFG_MIN_WIDTH, 16'd1000));
        dir_rows.push_back(cfg_row(CFG_MAX_WIDTH, 16'd200));
        dir_rows.push_back(cfg_row(CFG_TRIM_OFFSET, 16'd0));
        dir_rows.push_back(set_row(16'd50, 1'b1, 16'hFFFF));
        dir_rows.push_back(set_row(16'd1100, 1'b1, 16'hFFFF));
        // ramp division at both ends
        dir_rows.push_back(cfg_row(CFG_RAMP_FRAMES, 16'd1023));
        dir_rows.push_back(cfg_row(CFG_MIN_STEP, 16'd0));
        dir_rows.push_back(tick_row(1'b0, 1'b0, 1'b0, 16'd0));
        dir_rows.push_back(cfg_row(CFG_RAMP_FRAMES, 16'd1));
        dir_rows.push_back(tick_row(1'b0, 1'b0, 1'b0, 16'd0));
        // zero step, width past the frame, zero width, spare indexes
        dir_rows.push_back(cfg_row(CFG_FRAME_LENGTH, 16'd4));
        dir_rows.push_back(cfg_row(CFG_MIN_WIDTH, 16'd0));
        dir_rows.push_back(cfg_row(CFG_MAX_WIDTH, 16'hFFFF));
        dir_rows.push_back(cfg_row(CFG_RAMP_FRAMES, 16'd0));
        dir_rows.push_back(set_row(16'd0, 1'b1, 16'd200));
        dir_rows.push_back(tick_row(1'b1, 1'b1, 1'b1, 16'd200));
        dir_rows.push_back(tick_row(1'b1, 1'b1, 1'b0, 16'd200));
        dir_rows.push_back(tick_row(1'b1, 1'b1, 1'b0, 16'd200));
        dir_rows.push_back(tick_row(1'b1, 1'b1, 1'b0, 16'd200));
        dir_rows.push_back(cfg_row(CFG_MIN_STEP, 16'hFFFF));
        dir_rows.push_back(tick_row(1'b1, 1'b0, 1'b1, 16'd0));
        dir_rows.push_back(tick_row(1'b1, 1'b0, 1'b0, 16'd0));
        dir_rows.push_back(cfg_row(CFG_SPARE_6, 16'hFFFF));
        dir_rows.push_back(cfg_row(CFG_SPARE_7, 16'hFFFF));
        dir_rows.push_back(tick_row(1'b1, 1'b0, 1'b0, 16'd0));

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                wait_drain();
                cfg_write(dir_rows[i].reg_idx, dir_rows[i].value);
            end else begin
                it.req_type        = (dir_rows[i].kind == ROW_SET) ? REQ_SET : REQ_TICK;
                it.requested_width = dir_rows[i].value;
                pace();
                send_item(it, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        ph = 0;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            wait_drain();
            min_v   = 16'($urandom_range(0, 40));
            max_v   = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(0, 40))
                                                  : min_v + 16'($urandom_range(0, 80));
            trim_v  = 8'($urandom_range(0, 255));
            step_v  = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
            ramp_v  = ($urandom_range(0, 5) == 0) ? 10'($urandom_range(0, 1023))
                                                  : 10'($urandom_range(0, 6));
            frame_v = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 1))
                                                  : 16'($urandom_range(2, 48));
            wmax    = 16'($urandom_range(60, 200));
            case (ph)
                0: begin
                    min_v = 16'd0; max_v = 16'hFFFF; trim_v = 8'h7F;
                    step_v = 16'hFFFF; ramp_v = 10'd1023; frame_v = 16'hFFFF; wmax = 16'hFFFF;
                end
                1: begin
                    min_v = 16'd0; max_v = 16'd0; trim_v = 8'h80;
                    step_v = 16'd0; ramp_v = 10'd0; frame_v = 16'd0; wmax = 16'hFFFF;
                end
                2: begin
                    min_v = 16'hFFFF; max_v = 16'd0;
                    step_v = 16'd1; ramp_v = 10'd1; frame_v = 16'd1; wmax = 16'hFFFF;
                end
                3: begin
                    min_v = 16'd0; max_v = 16'hFFFF; trim_v = 8'd0;
                    step_v = 16'd0; ramp_v = 10'd1023; frame_v = 16'd2; wmax = 16'hFFFF;
                end
                default: ;
            endcase
            cfg_write(CFG_MIN_WIDTH, min_v);
            cfg_write(CFG_MAX_WIDTH, max_v);
            cfg_write(CFG_TRIM_OFFSET, {8'($urandom), trim_v});
            cfg_write(CFG_MIN_STEP, step_v);
            cfg_write(CFG_RAMP_FRAMES, {6'($urandom), ramp_v});
            cfg_write(CFG_FRAME_LENGTH, frame_v);
            if ($urandom_range(0, 3) == 0)
                cfg_write(($urandom_range(0, 1) == 0) ? CFG_SPARE_6 : CFG_SPARE_7, 16'($urandom));

            n = $urandom_range(25, 60);
            set_pct = $urandom_range(5, 30);
            repeat (n) begin
                it.req_type        = ($urandom_range(0, 99) < set_pct) ? REQ_SET : REQ_TICK;
                it.requested_width = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                                 : 16'($urandom_range(0, wmax));
                pace();
                send_item(it, 1'b0, '0);
                random_sent++;
            end
            ph++;
        end

        wait_drain();
        repeat (40) @(posedge aclk);

        $display("Sent %0d items (%0d set-target) across %0d random phases, %0d register writes.",
                 items_sent, sets_sent, ph, cfg_writes);
        $display("Checked %0d results, %0d frame starts, %0d mismatches.",
                 results_seen, frames_seen, mismatches);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- servo_pwm_slew_generator.f -----
hdl/svpwm_pkg.sv
hdl/svpwm_div.sv
hdl/svpwm_ctrl.sv
hdl/svpwm_dpath.sv
hdl/servo_pwm_slew_generator.sv
test/servo_pwm_slew_generator_tb.sv
